FILE: rtl/agacc_pkg.sv
// Shared types and constants of the arrival group accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package agacc_pkg;

	// Default time stamp width, handed to the top level parameter.
	localparam int TIME_BITS_DEF = 48;

	// Queue depths (powers of two).
	localparam int IQ_DEPTH = 2;
	localparam int OQ_DEPTH = 4;

	// Field widths fixed by the interface.
	localparam int GAP_W       = 20;
	localparam int VAR_W       = 21;
	localparam int CNT_W       = 16;
	localparam int BYTES_W     = 32;
	localparam int PKT_BYTES_W = 16;

	// Register map, index = paddr[3:2].
	localparam logic [1:0] REG_DEP_LIMIT = 2'd0;
	localparam logic [1:0] REG_ARR_LIMIT = 2'd1;
	localparam logic [1:0] REG_VAR_LIMIT = 2'd2;

	localparam logic [GAP_W-1:0] DEP_LIMIT_RST = 20'd5000;
	localparam logic [GAP_W-1:0] ARR_LIMIT_RST = 20'd5000;
	localparam logic [VAR_W-1:0] VAR_LIMIT_RST = 21'd0;

	// Per-record flags set by the front end.
	typedef struct packed {
		logic usable;
		logic first;
		logic last;
	} rec_flags_t;

	localparam int FLAGS_W = $bits(rec_flags_t);

	// Write request from the grouping stage into the result queue.
	typedef struct packed {
		logic first_slot;
		logic second_slot;
	} oq_push_t;

endpackage

`default_nettype wire

FILE: rtl/agacc_front.sv
// Front end: takes feedback records, flags them, and queues them.
// Depends on agacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agacc_front
	import agacc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int DEPTH     = IQ_DEPTH,
	localparam int IW       = FLAGS_W + 2 * TIME_BITS + PKT_BYTES_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   record_present,
	input  wire logic                   was_sent,
	input  wire logic                   was_received,
	input  wire logic [TIME_BITS-1:0]   departure_us,
	input  wire logic [TIME_BITS-1:0]   arrival_us,
	input  wire logic [PKT_BYTES_W-1:0] packet_bytes,
	input  wire logic                   window_first,
	input  wire logic                   window_last,
	output logic                        head_valid,
	output logic [IW-1:0]               head_data,
	input  wire logic                   take
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [IW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	rec_flags_t    flags;
	logic          push, pop;

	always_comb begin
		flags.usable = record_present & was_sent & was_received;
		flags.first  = window_first;
		flags.last   = window_last;
	end

	assign in_stall   = (cnt_q == FULL);
	assign push       = in_valid & ~in_stall;
	assign head_valid = (cnt_q != '0);
	assign pop        = head_valid & take;
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {flags, departure_us, arrival_us, packet_bytes};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

`ifndef SYNTH
	a_iq_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL)
		else $error("input queue overfilled");
`endif

endmodule

`default_nettype wire

FILE: rtl/agacc_back.sv
// Grouping stage: applies one queued record per cycle to the open group while
// the result queue has room, and emits closed and final group summaries. Depends on agacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agacc_back
	import agacc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IW       = FLAGS_W + 2 * TIME_BITS + PKT_BYTES_W,
	localparam int GW       = CNT_W + BYTES_W + 4 * TIME_BITS + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire logic [IW-1:0]    head_data,
	output logic                  take,
	input  wire logic [GAP_W-1:0] dep_limit,
	input  wire logic [GAP_W-1:0] arr_limit,
	input  wire logic [VAR_W-1:0] var_limit,
	input  wire logic             room,
	output oq_push_t              push,
	output logic [GW-1:0]         res0,
	output logic [GW-1:0]         res1
);

	rec_flags_t             flags;
	logic [TIME_BITS-1:0]   dep, arr;
	logic [PKT_BYTES_W-1:0] bytes;

	logic                   group_open_q;
	logic [CNT_W-1:0]       count_q, count_nxt;
	logic [BYTES_W-1:0]     bytes_q, bytes_nxt;
	logic [TIME_BITS-1:0]   fdep_q, ldep_q, farr_q, larr_q;
	logic [TIME_BITS-1:0]   fdep_nxt, ldep_nxt, farr_nxt, larr_nxt;

	logic [TIME_BITS:0]     dg_w, ag_w;
	logic [TIME_BITS-1:0]   dg, ag;
	logic                   dep_ge, arr_ge, dep_ok, arr_ok, dg_big, var_ok, join_ok;
	logic signed [VAR_W+1:0] var_diff, var_lim;
	logic [BYTES_W:0]       bsum;
	logic                   open_eff, do_start, do_append, do_close, added;

	assign {flags, dep, arr, bytes} = head_data;
	assign take = head_valid & room;

	// gaps against the last packet of the group; the borrow tells order
	assign dg_w   = {1'b0, dep} - {1'b0, ldep_q};
	assign ag_w   = {1'b0, arr} - {1'b0, larr_q};
	assign dep_ge = ~dg_w[TIME_BITS];
	assign arr_ge = ~ag_w[TIME_BITS];
	assign dg     = dg_w[TIME_BITS-1:0];
	assign ag     = ag_w[TIME_BITS-1:0];

	assign dep_ok = (dg <= {{(TIME_BITS - GAP_W){1'b0}}, dep_limit});
	assign arr_ok = (ag <= {{(TIME_BITS - GAP_W){1'b0}}, arr_limit});

	// With the arrival gap in range, a departure gap at or above 2^VAR_W gives
	// a variation below any legal limit; otherwise a narrow signed compare.
	assign dg_big   = |dg[TIME_BITS-1:VAR_W];
	assign var_diff = $signed({2'b00, ag[VAR_W-1:0]}) - $signed({2'b00, dg[VAR_W-1:0]});
	assign var_lim  = $signed({{2{var_limit[VAR_W-1]}}, var_limit});
	assign var_ok   = dg_big | (var_diff < var_lim);
	assign join_ok  = dep_ok | (arr_ok & var_ok);

	assign bsum = {1'b0, bytes_q} + {{(BYTES_W - PKT_BYTES_W + 1){1'b0}}, bytes};

	always_comb begin
		open_eff  = group_open_q & ~flags.first;
		do_start  = 1'b0;
		do_append = 1'b0;
		do_close  = 1'b0;
		if (flags.usable) begin
			if (!open_eff) begin
				do_start = 1'b1;
			end else if (arr_ge && dep_ge) begin
				if (join_ok) begin
					do_append = 1'b1;
				end else begin
					do_close = 1'b1;
					do_start = 1'b1;
				end
			end
		end
		added = do_start | do_append;

		count_nxt = count_q;
		bytes_nxt = bytes_q;
		fdep_nxt  = fdep_q;
		ldep_nxt  = ldep_q;
		farr_nxt  = farr_q;
		larr_nxt  = larr_q;
		if (do_start) begin
			count_nxt = {{(CNT_W - 1){1'b0}}, 1'b1};
			bytes_nxt = {{(BYTES_W - PKT_BYTES_W){1'b0}}, bytes};
			fdep_nxt  = dep;
			ldep_nxt  = dep;
			farr_nxt  = arr;
			larr_nxt  = arr;
		end else if (do_append) begin
			// both totals saturate
			if (count_q != '1) begin
				count_nxt = count_q + CNT_W'(1);
			end
			bytes_nxt = bsum[BYTES_W] ? '1 : bsum[BYTES_W-1:0];
			ldep_nxt  = dep;
			larr_nxt  = arr;
		end
	end

	// closed group goes first, the window's final group after it
	assign push.first_slot  = take & (do_close | (flags.last & added));
	assign push.second_slot = take & do_close & flags.last;

	assign res1 = {count_nxt, bytes_nxt, fdep_nxt, ldep_nxt, farr_nxt, larr_nxt, 1'b1};
	assign res0 = do_close ? {count_q, bytes_q, fdep_q, ldep_q, farr_q, larr_q, 1'b0} : res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_open_q <= 1'b0;
			count_q      <= '0;
			bytes_q      <= '0;
			fdep_q       <= '0;
			ldep_q       <= '0;
			farr_q       <= '0;
			larr_q       <= '0;
		end else if (take) begin
			group_open_q <= (open_eff | do_start) & ~flags.last;
			count_q      <= count_nxt;
			bytes_q      <= bytes_nxt;
			fdep_q       <= fdep_nxt;
			ldep_q       <= ldep_nxt;
			farr_q       <= farr_nxt;
			larr_q       <= larr_nxt;
		end
	end

`ifndef SYNTH
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_slot |-> (take && flags.last && push.first_slot))
		else $error("second result without window end");
	a_closed_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && flags.last) |=> !group_open_q)
		else $error("group still open after window end");
	a_open_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		group_open_q |-> (count_q != '0))
		else $error("open group with no packets");
`endif

endmodule

`default_nettype wire

FILE: rtl/agacc_outq.sv
// Result queue: takes up to two group summaries a cycle, hands out one beat
// per cycle on the output channel unless stalled. Depends on agacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agacc_outq
	import agacc_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = OQ_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire oq_push_t         push,
	input  wire logic [WIDTH-1:0] res0,
	input  wire logic [WIDTH-1:0] res1,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [WIDTH-1:0]      out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL     = CW'(DEPTH);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CW-1:0]    cnt_q, push_n;
	logic             pop;

	assign room      = (cnt_q <= ROOM_MAX);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign out_data  = mem_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + PW'(1);
	assign push_n    = CW'(push.first_slot) + CW'(push.second_slot);

	always_ff @(posedge clk) begin
		if (push.first_slot) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push.second_slot) begin
			mem_q[wr_ptr_p1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + push_n - CW'(pop);
		end
	end

`ifndef SYNTH
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL)
		else $error("result queue overfilled");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first_slot || push.second_slot) |-> room)
		else $error("result written without room for two");
`endif

endmodule

`default_nettype wire

FILE: rtl/arrival_group_accumulator.sv
// Top level of the arrival group accumulator: register port, front end,
// grouping stage and result queue. Depends on agacc_pkg and the agacc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Takes one per-packet feedback record per cycle while in_stall is low, in
// sequence order, and groups the records of a feedback window into arrival
// groups. Each closed group leaves as one beat with its packet count, byte
// total and first/last departure and arrival times; at window end the open
// group leaves too (final_of_window set) when the last record joined a group.
// A record is taken every cycle as long as results drain: each record can
// cost zero, one or two result beats and the output side moves one beat a
// cycle unless stalled, so a stream of records that each close a group and
// end a window is held back by the output side. The grouping stage applies
// one record a cycle to the open group's registers (a wide subtract and a few
// compares); it moves a record only when the four-entry result queue has room
// for two beats, and the two-entry record queue in front of it absorbs the
// difference. Limits are written over the APB port at 0x0 (departure gap),
// 0x4 (arrival gap) and 0x8 (delay variation, 21-bit two's complement); the
// user must write them only while the block is idle, as the block itself does
// not enforce it. There is no clearing pass.

module arrival_group_accumulator
	import agacc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// record channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   record_present,
	input  wire logic                   was_sent,
	input  wire logic                   was_received,
	input  wire logic [TIME_BITS-1:0]   departure_us,
	input  wire logic [TIME_BITS-1:0]   arrival_us,
	input  wire logic [PKT_BYTES_W-1:0] packet_bytes,
	input  wire logic                   window_first,
	input  wire logic                   window_last,
	// group channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [CNT_W-1:0]            group_packets,
	output logic [BYTES_W-1:0]          group_bytes,
	output logic [TIME_BITS-1:0]        group_first_departure_us,
	output logic [TIME_BITS-1:0]        group_last_departure_us,
	output logic [TIME_BITS-1:0]        group_first_arrival_us,
	output logic [TIME_BITS-1:0]        group_last_arrival_us,
	output logic                        final_of_window,
	// register port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [3:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IW = FLAGS_W + 2 * TIME_BITS + PKT_BYTES_W;
	localparam int GW = CNT_W + BYTES_W + 4 * TIME_BITS + 1;

	logic [GAP_W-1:0] dep_limit_q, arr_limit_q;
	logic [VAR_W-1:0] var_limit_q;
	logic             cfg_wr;

	logic             head_valid, take, room;
	logic [IW-1:0]    head_data;
	oq_push_t         push;
	logic [GW-1:0]    res0, res1, out_data;

	// ---- register port: pready held high, writes in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_limit_q <= DEP_LIMIT_RST;
			arr_limit_q <= ARR_LIMIT_RST;
			var_limit_q <= VAR_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DEP_LIMIT: dep_limit_q <= pwdata[GAP_W-1:0];
				REG_ARR_LIMIT: arr_limit_q <= pwdata[GAP_W-1:0];
				REG_VAR_LIMIT: var_limit_q <= pwdata[VAR_W-1:0];
				default: ; // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEP_LIMIT: prdata = {{(32 - GAP_W){1'b0}}, dep_limit_q};
			REG_ARR_LIMIT: prdata = {{(32 - GAP_W){1'b0}}, arr_limit_q};
			REG_VAR_LIMIT: prdata = {{(32 - VAR_W){1'b0}}, var_limit_q};
			default:       prdata = '0;
		endcase
	end

	// ---- front end: flag and queue records
	agacc_front #(
		.TIME_BITS (TIME_BITS),
		.DEPTH     (IQ_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.record_present (record_present),
		.was_sent       (was_sent),
		.was_received   (was_received),
		.departure_us   (departure_us),
		.arrival_us     (arrival_us),
		.packet_bytes   (packet_bytes),
		.window_first   (window_first),
		.window_last    (window_last),
		.head_valid     (head_valid),
		.head_data      (head_data),
		.take           (take)
	);

	// ---- grouping stage
	agacc_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.take       (take),
		.dep_limit  (dep_limit_q),
		.arr_limit  (arr_limit_q),
		.var_limit  (var_limit_q),
		.room       (room),
		.push       (push),
		.res0       (res0),
		.res1       (res1)
	);

	// ---- result queue, one beat a cycle out unless stalled
	agacc_outq #(
		.WIDTH (GW),
		.DEPTH (OQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign {group_packets, group_bytes, group_first_departure_us, group_last_departure_us,
		group_first_arrival_us, group_last_arrival_us, final_of_window} = out_data;

endmodule

`default_nettype wire

FILE: dv/tb_arrival_group_accumulator.sv
// Testbench for arrival_group_accumulator: directed and random feedback windows are
// fed in and every group beat is checked against a grouping predictor kept here.
// Depends on agacc_pkg and the RTL top level arrival_group_accumulator.
`timescale 1ns / 1ps

module tb_arrival_group_accumulator
	import agacc_pkg::*;
();

	localparam int TW            = TIME_BITS_DEF;
	localparam int IDLE_PCT      = 26;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_REPORTS   = 10;

	// One feedback record as offered on the record channel.
	typedef struct packed {
		logic                   present;
		logic                   sent;
		logic                   received;
		logic [TW-1:0]          departure;
		logic [TW-1:0]          arrival;
		logic [PKT_BYTES_W-1:0] pkt_bytes;
		logic                   win_first;
		logic                   win_last;
	} record_t;

	// One group summary as it leaves on the group channel.
	typedef struct packed {
		logic [CNT_W-1:0]   packets;
		logic [BYTES_W-1:0] total;
		logic [TW-1:0]      dep_first;
		logic [TW-1:0]      dep_last;
		logic [TW-1:0]      arr_first;
		logic [TW-1:0]      arr_last;
		logic               closes_window;
	} group_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   record_present = 1'b0;
	logic                   was_sent = 1'b0;
	logic                   was_received = 1'b0;
	logic [TW-1:0]          departure_us = '0;
	logic [TW-1:0]          arrival_us = '0;
	logic [PKT_BYTES_W-1:0] packet_bytes = '0;
	logic                   window_first = 1'b0;
	logic                   window_last = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CNT_W-1:0]       group_packets;
	logic [BYTES_W-1:0]     group_bytes;
	logic [TW-1:0]          group_first_departure_us;
	logic [TW-1:0]          group_last_departure_us;
	logic [TW-1:0]          group_first_arrival_us;
	logic [TW-1:0]          group_last_arrival_us;
	logic                   final_of_window;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [3:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Predictor copy of the limits and the open group.
	logic [GAP_W-1:0]        dep_limit = DEP_LIMIT_RST;
	logic [GAP_W-1:0]        arr_limit = ARR_LIMIT_RST;
	logic signed [VAR_W-1:0] var_limit = VAR_LIMIT_RST;
	logic                    grp_open = 1'b0;
	group_t                  open_grp = '0;
	group_t                  expected_groups[$];

	// Stimulus time cursors of the window being generated.
	logic [TW-1:0] send_dep = '0;
	logic [TW-1:0] send_arr = '0;

	logic sender_idles = 1'b1;
	logic receiver_idles = 1'b1;
	int   hold_request = 0;
	int   mismatches = 0;
	int   cycles = 0;

	arrival_group_accumulator #(
		.TIME_BITS(TW)
	) dut (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.in_valid                 (in_valid),
		.in_stall                 (in_stall),
		.record_present           (record_present),
		.was_sent                 (was_sent),
		.was_received             (was_received),
		.departure_us             (departure_us),
		.arrival_us               (arrival_us),
		.packet_bytes             (packet_bytes),
		.window_first             (window_first),
		.window_last              (window_last),
		.out_valid                (out_valid),
		.out_stall                (out_stall),
		.group_packets            (group_packets),
		.group_bytes              (group_bytes),
		.group_first_departure_us (group_first_departure_us),
		.group_last_departure_us  (group_last_departure_us),
		.group_first_arrival_us   (group_first_arrival_us),
		.group_last_arrival_us    (group_last_arrival_us),
		.final_of_window          (final_of_window),
		.psel                     (psel),
		.penable                  (penable),
		.pwrite                   (pwrite),
		.paddr                    (paddr),
		.pwdata                   (pwdata),
		.prdata                   (prdata),
		.pready                   (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endfunction

	function automatic void start_group(input record_t r);
		grp_open = 1'b1;
		open_grp.packets = CNT_W'(1);
		open_grp.total = BYTES_W'(r.pkt_bytes);
		open_grp.dep_first = r.departure;
		open_grp.dep_last = r.departure;
		open_grp.arr_first = r.arrival;
		open_grp.arr_last = r.arrival;
	endfunction

	// Apply one accepted record to the open group; queue the beats it causes.
	function automatic void predict_groups(input record_t r);
		logic                 added;
		logic [TW-1:0]        dg;
		logic [TW-1:0]        ag;
		logic signed [TW+1:0] variation;
		logic [BYTES_W:0]     sum;
		added = 1'b0;
		if (r.win_first)
			grp_open = 1'b0;
		if (r.present && r.sent && r.received) begin
			if (!grp_open) begin
				start_group(r);
				added = 1'b1;
			end else if (r.arrival >= open_grp.arr_last && r.departure >= open_grp.dep_last) begin
				dg = r.departure - open_grp.dep_last;
				ag = r.arrival - open_grp.arr_last;
				// delay variation = arrival gap - departure gap, two guard bits
				variation = $signed({2'b00, ag}) - $signed({2'b00, dg});
				if (dg <= dep_limit || (ag <= arr_limit && variation < var_limit)) begin
					if (open_grp.packets != '1)
						open_grp.packets = open_grp.packets + 1'b1;
					sum = {1'b0, open_grp.total} + r.pkt_bytes;
					open_grp.total = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
					open_grp.dep_last = r.departure;
					open_grp.arr_last = r.arrival;
				end else begin
					open_grp.closes_window = 1'b0;
					expected_groups.insert(expected_groups.size(), open_grp);
					start_group(r);
				end
				added = 1'b1;
			end
		end
		if (r.win_last) begin
			// skipped last record: the open group is dropped silently
			if (added) begin
				open_grp.closes_window = 1'b1;
				expected_groups.insert(expected_groups.size(), open_grp);
			end
			grp_open = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Group channel: sink with random stall, long hold-off, and checker
	// ------------------------------------------------------------------

	function automatic void check_group();
		group_t want;
		if (expected_groups.size() == 0) begin
			flag_mismatch("group beat with nothing expected, packets", '0, group_packets);
			return;
		end
		want = expected_groups[0];
		expected_groups.delete(0);
		if (want.packets !== group_packets)
			flag_mismatch("group_packets", want.packets, group_packets);
		if (want.total !== group_bytes)
			flag_mismatch("group_bytes", want.total, group_bytes);
		if (want.dep_first !== group_first_departure_us)
			flag_mismatch("group_first_departure_us", want.dep_first, group_first_departure_us);
		if (want.dep_last !== group_last_departure_us)
			flag_mismatch("group_last_departure_us", want.dep_last, group_last_departure_us);
		if (want.arr_first !== group_first_arrival_us)
			flag_mismatch("group_first_arrival_us", want.arr_first, group_first_arrival_us);
		if (want.arr_last !== group_last_arrival_us)
			flag_mismatch("group_last_arrival_us", want.arr_last, group_last_arrival_us);
		if (want.closes_window !== final_of_window)
			flag_mismatch("final_of_window", want.closes_window, final_of_window);
	endfunction

	initial begin : group_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			// values seen here are the ones the block sampled at this edge
			if (arst_n && out_valid && !out_stall)
				check_group();
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= receiver_idles && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_arrival_group_accumulator: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Record channel and register port
	// ------------------------------------------------------------------

	// Offer one record, hold it until taken. Valid is left high on return so
	// back-to-back beats never see it drop within a step.
	task automatic send_record(input record_t r);
		while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		record_present <= r.present;
		was_sent <= r.sent;
		was_received <= r.received;
		departure_us <= r.departure;
		arrival_us <= r.arrival;
		packet_bytes <= r.pkt_bytes;
		window_first <= r.win_first;
		window_last <= r.win_last;
		do @(posedge clk); while (in_stall);
		predict_groups(r);
	endtask

	// Sender pauses until every expected group is back and the pipe is empty.
	task automatic drain_groups();
		in_valid <= 1'b0;
		while (expected_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write a limit, then read it back in a second transfer.
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] readback;
		mask = (idx == REG_VAR_LIMIT) ? 32'h001F_FFFF : 32'h000F_FFFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value & mask;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DEP_LIMIT: dep_limit = value[GAP_W-1:0];
			REG_ARR_LIMIT: arr_limit = value[GAP_W-1:0];
			REG_VAR_LIMIT: var_limit = value[VAR_W-1:0];
			default: ;
		endcase
		if ((readback & mask) !== (value & mask))
			flag_mismatch("register readback", value & mask, readback & mask);
	endtask

	task automatic program_limits(input int dep_v, input int arr_v, input int var_v);
		drain_groups();
		write_register(REG_DEP_LIMIT, dep_v);
		write_register(REG_ARR_LIMIT, arr_v);
		write_register(REG_VAR_LIMIT, var_v);
	endtask

	function automatic record_t pack_record(input logic [2:0] flags, input logic [TW-1:0] dep,
			input logic [TW-1:0] arr, input logic [PKT_BYTES_W-1:0] nbytes,
			input logic wf, input logic wl);
		record_t r;
		{r.present, r.sent, r.received} = flags;
		r.departure = dep;
		r.arrival = arr;
		r.pkt_bytes = nbytes;
		r.win_first = wf;
		r.win_last = wl;
		return r;
	endfunction

	// Random windows: mostly usable records whose gaps straddle the current
	// limits, plus skips, stray window marks and times that wrap at the top.
	task automatic send_random_windows(input int items);
		record_t r;
		int      sent;
		int      len;
		int      kind;
		longint  dgap;
		longint  dv;
		longint  mag;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			if ($urandom_range(7) == 0) begin
				send_dep = '1 - TW'($urandom_range(20000));
				send_arr = '1 - TW'($urandom_range(20000));
			end else begin
				send_dep = TW'({$urandom, $urandom});
				send_arr = TW'({$urandom, $urandom});
			end
			for (int i = 0; i < len; i++) begin
				{r.present, r.sent, r.received} = 3'b111;
				if ($urandom_range(9) == 0)
					{r.present, r.sent, r.received} = 3'($urandom);
				r.win_first = (i == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 2);
				r.win_last = (i == len - 1) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 3);
				case ($urandom_range(15))
					0: r.pkt_bytes = '0;
					1: r.pkt_bytes = '1;
					default: r.pkt_bytes = PKT_BYTES_W'($urandom);
				endcase

				// departure gap: inside, on the edge of, or past the limit, or going back
				kind = $urandom_range(19);
				if (kind < 10) begin
					dgap = longint'($urandom_range(dep_limit));
				end else if (kind < 12) begin
					dgap = longint'(dep_limit) + longint'($urandom_range(2)) - 1;
					if (dgap < 0)
						dgap = 0;
				end else if (kind < 16) begin
					dgap = longint'(dep_limit) + 1 + longint'($urandom_range(arr_limit + 16));
				end else if (kind < 18) begin
					dgap = longint'($urandom_range(1 << 22));
				end else begin
					dgap = -longint'($urandom_range(64, 1));
				end

				// delay variation around zero, around the limit, or arrival going back
				mag = (var_limit < 0) ? -longint'(var_limit) : longint'(var_limit);
				case ($urandom_range(9))
					0, 1, 2, 3, 4: dv = longint'($urandom_range(100)) - 50;
					5, 6: dv = longint'(var_limit) + longint'($urandom_range(2)) - 1;
					7, 8: dv = longint'($urandom_range(2 * mag + 32)) - mag - 16;
					default: dv = -dgap - longint'($urandom_range(64, 1));
				endcase

				r.departure = send_dep + TW'(dgap);
				r.arrival = send_arr + TW'(dgap + dv);
				if (dgap >= 0 && dgap + dv >= 0) begin
					send_dep = r.departure;
					send_arr = r.arrival;
				end
				send_record(r);
			end
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset limits: 5000 us gaps, variation must be negative.
	task automatic test_directed_cases();
		// single-record windows, usable and each missing flag
		send_record(pack_record(3'b111, 1000, 2000, 100, 1'b1, 1'b1));
		send_record(pack_record(3'b011, 1100, 2100, 100, 1'b1, 1'b1));
		send_record(pack_record(3'b101, 1200, 2200, 100, 1'b1, 1'b1));
		send_record(pack_record(3'b110, 1300, 2300, 100, 1'b1, 1'b1));
		// departure gap at the limit, join by arrival test, split, both skips
		send_record(pack_record(3'b111, 10000, 20000, 0, 1'b1, 1'b0));
		send_record(pack_record(3'b111, 15000, 26000, 10, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 20001, 30000, 20, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 25002, 35002, 30, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 25003, 35001, 40, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 25001, 35010, 50, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 30003, 35003, 60, 1'b0, 1'b1));
		// window ends on a skipped record: open group dropped unemitted
		send_record(pack_record(3'b111, 100000, 100000, 500, 1'b1, 1'b0));
		send_record(pack_record(3'b111, 99999, 100001, 500, 1'b0, 1'b1));
		// first mark in mid window drops the open group
		send_record(pack_record(3'b111, 200000, 200000, 7, 1'b1, 1'b0));
		send_record(pack_record(3'b111, 200010, 200010, 8, 1'b1, 1'b0));
		send_record(pack_record(3'b111, 200020, 200020, 9, 1'b0, 1'b1));
		// no first mark after a window end; then close and final on one record
		send_record(pack_record(3'b111, 300000, 300000, 11, 1'b0, 1'b0));
		send_record(pack_record(3'b111, 10300000, 10300000, 12, 1'b0, 1'b1));
		// extremes of times and sizes
		send_record(pack_record(3'b111, '1, '1, '1, 1'b1, 1'b0));
		send_record(pack_record(3'b111, '0, '0, '0, 1'b0, 1'b0));
		send_record(pack_record(3'b111, '1, '1, '1, 1'b0, 1'b1));
		drain_groups();
	endtask

	// Receiver holds off long enough for both queues to fill and the input to
	// stall while the sender keeps offering; then the sender waits for all.
	task automatic test_backpressure();
		sender_idles = 1'b0;
		hold_request = 500;
		repeat (40)
			send_record(pack_record(3'b111, TW'({$urandom, $urandom}),
				TW'({$urandom, $urandom}), PKT_BYTES_W'($urandom), 1'b1, 1'b1));
		sender_idles = 1'b1;
		drain_groups();
	endtask

	task automatic test_full_rate();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		send_random_windows(300);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		drain_groups();
	endtask

	// One long window of full-size packets: large counts and byte totals.
	task automatic test_long_window();
		record_t r;
		r = pack_record(3'b111, 48'h1234_5678_9ABC, 48'h2345_6789_ABCD, '1, 1'b1, 1'b0);
		sender_idles = 1'b0;
		send_record(r);
		r.win_first = 1'b0;
		repeat (150) send_record(r);
		r.win_last = 1'b1;
		send_record(r);
		sender_idles = 1'b1;
		drain_groups();
	endtask

	task automatic test_limit_settings();
		program_limits(0, 0, 0);
		send_random_windows(300);
		program_limits(1000000, 1000000, 1000000);
		send_random_windows(300);
		program_limits(100, 3000, -1000000);
		send_random_windows(300);
		program_limits(1000000, 0, -1);
		send_random_windows(300);
		program_limits($urandom_range(1000000), $urandom_range(1000000),
			int'($urandom_range(2000000)) - 1000000);
		send_random_windows(300);
	endtask

	initial begin : run
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_backpressure();
		test_full_rate();
		test_long_window();
		test_limit_settings();
		drain_groups();
		if (mismatches == 0 && expected_groups.size() == 0)
			$display("tb_arrival_group_accumulator: PASS");
		else
			$display("tb_arrival_group_accumulator: FAIL");
		$finish;
	end

endmodule
